@@ hdl/text_console_writer_top_defines.svh @@
// Assertion macros for the text console writer checker.
// No dependencies; included by the checker file only.
`ifndef TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH

// Same-cycle implication, gated by the active-low reset.
`define TCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated by the active-low reset.
`define TCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/tcw_pkg.sv @@
// Shared types, constants and codes of the text console writer.
// No dependencies; every other file but the assertion macros header imports it.
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;
    localparam int QUEUE_DEPTH = 2;

    localparam int FUNC_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int ADDR_W  = 11;
    localparam int DATA_W  = 16;
    localparam int CUR_W   = 11;
    localparam int COLOR_W = 4;
    localparam int ATTR_W  = 2 * COLOR_W;
    localparam int CFG_IDX_W = 1;

    // request function codes
    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // control characters
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

    localparam logic [DATA_W-1:0] RESET_CELL = 16'h0720;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 1'b1;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_RETURN,
        OP_TAB,
        OP_CLEAR,
        OP_READ,
        OP_READ_NULL,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] char_code;
        logic [ADDR_W-1:0] cell_address;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL_START,
        ST_SCROLL,
        ST_BLANK
    } t_state;

endpackage

@@ hdl/tcw_if.sv @@
// Request and result channel interfaces of the text console writer.
// Depends on tcw_pkg.
interface tcw_req_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_address;

    modport source (output valid, output func, output char_code, output cell_address,
                    input ready);
    modport sink   (input valid, input func, input char_code, input cell_address,
                    output ready);
endinterface

interface tcw_rsp_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] cell_data;
    logic [CUR_W-1:0]  cursor_position;
    logic              scrolled;

    modport source (output valid, output cell_data, output cursor_position,
                    output scrolled, input ready);
    modport sink   (input valid, input cell_data, input cursor_position,
                    input scrolled, output ready);
endinterface

@@ hdl/tcw_front.sv @@
// Front end: takes requests and sorts them into internal commands.
// Depends on tcw_pkg and tcw_req_if.
module tcw_front #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    tcw_req_if.sink       i_req,
    input  logic          i_full,
    input  logic          i_init_busy,
    output logic          o_push,
    output tcw_pkg::t_cmd o_cmd
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int IW    = $clog2(CELLS);
    localparam logic [IW+ADDR_W-1:0] CELLS_X = (IW + ADDR_W)'(CELLS);

    logic in_range;

    assign in_range    = {{IW{1'b0}}, i_req.cell_address} < CELLS_X;
    assign i_req.ready = !i_full && !i_init_busy;
    assign o_push      = i_req.valid && i_req.ready;

    always_comb begin
        o_cmd.char_code    = i_req.char_code;
        o_cmd.cell_address = i_req.cell_address;
        unique case (i_req.func)
            FUNC_PUT: begin
                unique case (i_req.char_code)
                    CH_NEWLINE: o_cmd.op = OP_NEWLINE;
                    CH_RETURN:  o_cmd.op = OP_RETURN;
                    CH_TAB:     o_cmd.op = OP_TAB;
                    default:    o_cmd.op = OP_PUT;
                endcase
            end
            FUNC_CLEAR: o_cmd.op = OP_CLEAR;
            FUNC_READ:  o_cmd.op = in_range ? OP_READ : OP_READ_NULL;
            default:    o_cmd.op = OP_NOP;
        endcase
    end

endmodule

@@ hdl/tcw_queue.sv @@
// Short command queue between front and back end.
// Depends on tcw_pkg.
module tcw_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcw_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output tcw_pkg::t_cmd o_cmd
);
    import tcw_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam logic [PW:0] DEPTH_C = (PW + 1)'(QUEUE_DEPTH);

    t_cmd          r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [PW:0]   r_cnt, n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == DEPTH_C);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_slot[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = do_push ? r_wr + PW'(1) : r_wr;
        n_rd  = do_pop  ? r_rd + PW'(1) : r_rd;
        n_cnt = r_cnt + (PW + 1)'(do_push) - (PW + 1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

endmodule

@@ hdl/tcw_back.sv @@
// Back end: cell store, cursor, scroll and clear sequencer, result register.
// Depends on tcw_pkg and tcw_rsp_if.
module tcw_back #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    input  tcw_pkg::t_cmd                i_cmd,
    output logic                         o_pop,
    input  logic [tcw_pkg::COLOR_W-1:0]  i_fg,
    input  logic [tcw_pkg::COLOR_W-1:0]  i_bg,
    output logic                         o_init_busy,
    tcw_rsp_if.source                    o_rsp
);
    import tcw_pkg::*;

    localparam int CELLS      = COLUMNS * ROWS;
    localparam int LAST_START = COLUMNS * (ROWS - 1);
    localparam int IW         = $clog2(CELLS);
    localparam int CW         = $clog2(COLUMNS);

    localparam logic [IW:0]   CELLS_X = (IW + 1)'(CELLS);
    localparam logic [IW:0]   COLS_X  = (IW + 1)'(COLUMNS);
    localparam logic [IW-1:0] LAST_I  = IW'(LAST_START);
    localparam logic [IW-1:0] END_I   = IW'(CELLS - 1);
    localparam logic [IW-1:0] COLS_I  = IW'(COLUMNS);
    localparam logic [CW:0]   COLS_C  = (CW + 1)'(COLUMNS);

    logic [DATA_W-1:0] mem [CELLS];
    logic [DATA_W-1:0] r_rdata;

    t_state            r_state, n_state;
    logic [IW-1:0]     r_pos, n_pos;
    logic [CW-1:0]     r_col, n_col;
    logic [IW-1:0]     r_idx, n_idx;
    logic              r_scroll, n_scroll;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_data, n_out_data;
    logic [CUR_W-1:0]  r_out_cur, n_out_cur;
    logic              r_out_scr, n_out_scr;

    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [IW-1:0]     mem_raddr;

    logic [ATTR_W-1:0] attr;
    logic [DATA_W-1:0] blank;
    logic              slot_free;

    assign attr        = {i_bg, i_fg};
    assign blank       = {attr, CH_SPACE};
    assign slot_free   = !r_out_valid || o_rsp.ready;
    assign o_init_busy = (r_state == ST_INIT);

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.cell_data       = r_out_data;
    assign o_rsp.cursor_position = r_out_cur;
    assign o_rsp.scrolled        = r_out_scr;

    always_comb begin
        logic [IW:0]          nxt;
        logic [CW:0]          col_sum;
        logic [2:0]           tab_step;
        logic [IW:0]          rd_next;
        logic [IW+CUR_W-1:0]  cur_ext;
        logic [IW+ADDR_W-1:0] addr_ext;
        logic                 moves;
        logic                 load;
        logic [DATA_W-1:0]    load_data;
        logic                 load_scr;

        tab_step  = 3'd4 - {1'b0, r_pos[1:0]};
        col_sum   = {1'b0, r_col} + (CW + 1)'(tab_step);
        rd_next   = {1'b0, r_idx} + COLS_X + (IW + 1)'(1);
        addr_ext  = {{IW{1'b0}}, i_cmd.cell_address};
        nxt       = {1'b0, r_pos};
        moves     = 1'b0;
        load      = 1'b0;
        load_data = '0;
        load_scr  = 1'b0;

        n_state     = r_state;
        n_pos       = r_pos;
        n_col       = r_col;
        n_idx       = r_idx;
        n_scroll    = r_scroll;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_data  = r_out_data;
        n_out_cur   = r_out_cur;
        n_out_scr   = r_out_scr;

        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = blank;
        mem_re    = 1'b0;
        mem_raddr = r_idx;
        o_pop     = 1'b0;

        unique case (r_state)
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = RESET_CELL;
                if (r_idx == END_I) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid && slot_free) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.op)
                        OP_PUT: begin
                            mem_we    = 1'b1;
                            mem_waddr = r_pos;
                            mem_wdata = {attr, i_cmd.char_code};
                            moves     = 1'b1;
                            nxt       = {1'b0, r_pos} + (IW + 1)'(1);
                            n_col     = ({1'b0, r_col} == COLS_C - (CW + 1)'(1))
                                        ? '0 : r_col + CW'(1);
                        end
                        OP_NEWLINE: begin
                            moves = 1'b1;
                            nxt   = {1'b0, r_pos} - {{(IW + 1 - CW){1'b0}}, r_col} + COLS_X;
                            n_col = '0;
                        end
                        OP_RETURN: begin
                            moves = 1'b1;
                            nxt   = {1'b0, r_pos} - {{(IW + 1 - CW){1'b0}}, r_col};
                            n_col = '0;
                        end
                        OP_TAB: begin
                            moves = 1'b1;
                            nxt   = {1'b0, r_pos} + (IW + 1)'(tab_step);
                            n_col = (col_sum >= COLS_C) ? CW'(col_sum - COLS_C)
                                                        : col_sum[CW-1:0];
                        end
                        OP_CLEAR: begin
                            n_pos    = '0;
                            n_col    = '0;
                            n_idx    = '0;
                            n_scroll = 1'b0;
                            n_state  = ST_BLANK;
                        end
                        OP_READ: begin
                            mem_re    = 1'b1;
                            mem_raddr = addr_ext[IW-1:0];
                            n_state   = ST_READ;
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                    if (moves) begin
                        if (nxt >= CELLS_X) begin
                            // ran off the end: scroll, cursor to start of last row
                            n_pos    = LAST_I;
                            n_col    = '0;
                            n_idx    = '0;
                            n_scroll = 1'b1;
                            n_state  = ST_SCROLL_START;
                        end else begin
                            n_pos = nxt[IW-1:0];
                            load  = 1'b1;
                        end
                    end
                end
            end
            ST_READ: begin
                load      = 1'b1;
                load_data = r_rdata;
                n_state   = ST_IDLE;
            end
            ST_SCROLL_START: begin
                mem_re    = 1'b1;
                mem_raddr = COLS_I;
                n_state   = ST_SCROLL;
            end
            ST_SCROLL: begin
                // copy cell idx+COLUMNS (read last cycle) down to idx
                mem_we    = 1'b1;
                mem_wdata = r_rdata;
                if (r_idx == LAST_I - IW'(1)) begin
                    n_idx   = LAST_I;
                    n_state = ST_BLANK;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = rd_next[IW-1:0];
                    n_idx     = r_idx + IW'(1);
                end
            end
            ST_BLANK: begin
                mem_we = 1'b1;
                if (r_idx == END_I) begin
                    load     = 1'b1;
                    load_scr = r_scroll;
                    n_state  = ST_IDLE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        cur_ext = {{CUR_W{1'b0}}, n_pos};
        if (load) begin
            n_out_valid = 1'b1;
            n_out_data  = load_data;
            n_out_cur   = cur_ext[CUR_W-1:0];
            n_out_scr   = load_scr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_pos       <= '0;
            r_col       <= '0;
            r_idx       <= '0;
            r_scroll    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_col       <= n_col;
            r_idx       <= n_idx;
            r_scroll    <= n_scroll;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_cur  <= n_out_cur;
        r_out_scr  <= n_out_scr;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

endmodule

@@ hdl/text_console_writer_top.sv @@
// Top level of the text console writer: configuration registers and wiring.
// Depends on tcw_pkg, tcw_if, tcw_front, tcw_queue and tcw_back.

// Text-mode console writer holding COLUMNS x ROWS cells of 16 bits (attribute
// in the high byte, character in the low byte) and a cursor. Each request on
// i_req gives exactly one result on o_rsp. A stream of put character, newline,
// carriage return and tab runs at one request per cycle while results are
// taken; a read passes through an extra state (registered cell-store read).
// A put, newline or tab that runs past the last cell scrolls: a priming read,
// then COLUMNS*(ROWS-1) cells copied through the cell store's separate read
// and write ports, one cell a cycle, then the last row of COLUMNS cells
// blanked. A clear writes every cell once. After reset the store is swept to
// light-grey blanks while i_req.ready stays low; configuration writes are taken
// throughout. A two-entry request queue sits between front and back end; the
// back end takes a new command only while the result register is empty or is
// being read. fg_color and bg_color apply to cells written or blanked after the
// write; change them only while the block is idle.
module text_console_writer_top #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tcw_req_if.sink                        i_req,
    tcw_rsp_if.source                      o_rsp,
    input  logic                           i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tcw_pkg::COLOR_W-1:0]    i_cfg_data
);
    import tcw_pkg::*;

    // colour registers
    logic [COLOR_W-1:0] r_fg, n_fg;
    logic [COLOR_W-1:0] r_bg, n_bg;

    // front to queue
    logic push;
    t_cmd push_cmd;
    logic full;

    // queue to back
    logic cmd_valid;
    t_cmd cmd;
    logic pop;
    logic init_busy;

    always_comb begin
        n_fg = r_fg;
        n_bg = r_bg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FG_COLOR: n_fg = i_cfg_data;
                CFG_BG_COLOR: n_bg = i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FG_RESET;
            r_bg <= BG_RESET;
        end else begin
            r_fg <= n_fg;
            r_bg <= n_bg;
        end
    end

    // classify requests; held off during the post-reset sweep
    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_req       (i_req),
        .i_full      (full),
        .i_init_busy (init_busy),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (cmd_valid),
        .o_cmd   (cmd)
    );

    // cell store, cursor and result register
    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .i_fg        (r_fg),
        .i_bg        (r_bg),
        .o_init_busy (init_busy),
        .o_rsp       (o_rsp)
    );

endmodule

@@ hdl/tcw_checker.sv @@
// Port-level checker of the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_top_defines.svh.
`include "text_console_writer_top_defines.svh"

module tcw_checker #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic [tcw_pkg::DATA_W-1:0]   i_cell_data,
    input logic [tcw_pkg::CUR_W-1:0]    i_cursor_position,
    input logic                         i_scrolled
);
    import tcw_pkg::*;

    localparam int CELLS      = COLUMNS * ROWS;
    localparam int LAST_START = COLUMNS * (ROWS - 1);

    `TCW_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready,
        i_rsp_valid && $stable(i_cell_data) && $stable(i_cursor_position)
        && $stable(i_scrolled), "stalled result changed")

    `TCW_ASSERT_IMP(a_scroll_cursor, i_clk, i_rst_n, i_rsp_valid && i_scrolled,
        i_cursor_position == CUR_W'(LAST_START), "scroll left cursor off last row")

    `TCW_ASSERT_IMP(a_scroll_no_data, i_clk, i_rst_n, i_rsp_valid && i_scrolled,
        i_cell_data == '0, "scrolling result carries cell data")

    `TCW_ASSERT_IMP(a_cursor_range, i_clk, i_rst_n, i_rsp_valid,
        int'(i_cursor_position) < CELLS, "cursor beyond last cell")

endmodule

bind text_console_writer_top tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_cell_data       (o_rsp.cell_data),
    .i_cursor_position (o_rsp.cursor_position),
    .i_scrolled        (o_rsp.scrolled)
);
